@@ rtl/core/ppmr_pkg.sv @@
// Package for the per-process mailbox rings: field widths, command codes,
// controller state type and control structs. No dependencies.
package ppmr_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned TYPE_W = 32;
  localparam int unsigned PAY_W  = 64;
  localparam int unsigned LEN_W  = 8;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FETCH
  } ppmr_state_e;

  // Slot store operation for one cycle
  typedef struct packed {
    logic clr;
    logic wr;
    logic rd;
  } slot_op_t;

  // Result register load request
  typedef struct packed {
    logic load;
    logic ok;
    logic from_mem;
  } rsp_ctl_t;

endpackage

@@ rtl/core/ppmr_cmd_if.sv @@
// Command channel of the mailbox rings: valid/ready plus the command word.
// Depends on ppmr_pkg for field widths.
interface ppmr_cmd_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [ppmr_pkg::ID_W-1:0]    queue_id;
  logic [ppmr_pkg::ID_W-1:0]    sender_id;
  logic [ppmr_pkg::TYPE_W-1:0]  msg_type;
  logic [ppmr_pkg::PAY_W-1:0]   payload;
  logic [ppmr_pkg::LEN_W-1:0]   length;

  modport source (
    output valid, command, queue_id, sender_id, msg_type, payload, length,
    input  ready
  );
  modport sink (
    input  valid, command, queue_id, sender_id, msg_type, payload, length,
    output ready
  );
endinterface

@@ rtl/core/ppmr_rsp_if.sv @@
// Result channel of the mailbox rings: valid/ready plus the result word.
// Depends on ppmr_pkg for field widths.
interface ppmr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [ppmr_pkg::ID_W-1:0]    out_sender_id;
  logic [ppmr_pkg::TYPE_W-1:0]  out_type;
  logic [ppmr_pkg::PAY_W-1:0]   out_payload;

  modport source (
    output valid, ok, out_sender_id, out_type, out_payload,
    input  ready
  );
  modport sink (
    input  valid, ok, out_sender_id, out_type, out_payload,
    output ready
  );
endinterface

@@ rtl/core/ppmr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ppmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ppmr_slots.sv @@
// Message slot store: sender/type memory and one byte-lane memory per
// payload byte. Depends on ppmr_pkg and ppmr_ram.
module ppmr_slots #(
  parameter int unsigned DEPTH         = 4096,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                          clk_i,
  input  ppmr_pkg::slot_op_t            op_i,
  input  logic [$clog2(DEPTH)-1:0]      addr_i,
  input  logic [ppmr_pkg::ID_W-1:0]     sender_i,
  input  logic [ppmr_pkg::TYPE_W-1:0]   type_i,
  input  logic [ppmr_pkg::PAY_W-1:0]    payload_i,
  input  logic [ppmr_pkg::LEN_W-1:0]    length_i,
  output logic [ppmr_pkg::ID_W-1:0]     sender_o,
  output logic [ppmr_pkg::TYPE_W-1:0]   type_o,
  output logic [ppmr_pkg::PAY_W-1:0]    payload_o
);
  import ppmr_pkg::*;

  localparam int unsigned META_W = ID_W + TYPE_W;

  logic [META_W-1:0] meta_rd;
  logic [7:0]        lane_rd [PAYLOAD_BYTES];

  ppmr_ram #(
    .WIDTH (META_W),
    .DEPTH (DEPTH)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (op_i.wr),
    .waddr_i (addr_i),
    .wdata_i ({sender_i, type_i}),
    .re_i    (op_i.rd),
    .raddr_i (addr_i),
    .rdata_o (meta_rd)
  );

  // Write only the lanes below the length; clear writes every lane
  for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_lane
    logic       lane_we;
    logic [7:0] lane_wd;

    assign lane_we = op_i.clr | (op_i.wr & (length_i > LEN_W'(k)));
    assign lane_wd = op_i.clr ? 8'd0 : payload_i[8*k +: 8];

    ppmr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
    ) u_lane_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we),
      .waddr_i (addr_i),
      .wdata_i (lane_wd),
      .re_i    (op_i.rd),
      .raddr_i (addr_i),
      .rdata_o (lane_rd[k])
    );
  end

  always_comb begin
    payload_o = '0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      payload_o[8*k +: 8] = lane_rd[k];
    end
  end

  assign sender_o = meta_rd[META_W-1:TYPE_W];
  assign type_o   = meta_rd[TYPE_W-1:0];

endmodule

@@ rtl/core/ppmr_ctrl.sv @@
// Sequencer of the mailbox rings: clear sweep, pointer memory lookup and
// update, slot store commands and result load. Depends on ppmr_pkg, ppmr_ram.
module ppmr_ctrl #(
  parameter int unsigned NUM_QUEUES  = 256,
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       command_i,
  input  logic [ppmr_pkg::ID_W-1:0]                  queue_id_i,
  input  logic                                       out_free_i,
  output ppmr_pkg::slot_op_t                         slot_op_o,
  output logic [$clog2(NUM_QUEUES*QUEUE_SLOTS)-1:0]  slot_addr_o,
  output ppmr_pkg::rsp_ctl_t                         rsp_ctl_o
);
  import ppmr_pkg::*;

  localparam int unsigned SLOTS = NUM_QUEUES * QUEUE_SLOTS;
  localparam int unsigned SAW   = $clog2(SLOTS);
  localparam int unsigned QW    = $clog2(NUM_QUEUES);
  localparam int unsigned PW    = $clog2(QUEUE_SLOTS);
  localparam logic [SAW-1:0]  LAST_SLOT = SAW'(SLOTS - 1);
  localparam logic [PW-1:0]   LAST_PTR  = PW'(QUEUE_SLOTS - 1);
  localparam logic [ID_W:0]   QID_LIM   = (ID_W + 1)'(NUM_QUEUES);

  ppmr_state_e     state_q, state_d;
  logic [SAW-1:0]  clr_cnt_q;
  logic            cmd_q;
  logic [ID_W-1:0] qid_q;

  logic            accept;
  logic [2*PW-1:0] ptr_rd;
  logic [PW-1:0]   wp, rp, wp_nxt, rp_nxt;
  logic            bad_id, full, empty, send_ok, recv_ok;
  logic [SAW-1:0]  slot_base;
  logic            ptr_we;
  logic [QW-1:0]   ptr_waddr;
  logic [2*PW-1:0] ptr_wdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  ppmr_ram #(
    .WIDTH (2 * PW),
    .DEPTH (NUM_QUEUES)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .re_i    (accept),
    .raddr_i (queue_id_i[QW-1:0]),
    .rdata_o (ptr_rd)
  );

  // Pointer word: read pointer in the upper half, write pointer below
  assign wp      = ptr_rd[PW-1:0];
  assign rp      = ptr_rd[2*PW-1:PW];
  assign wp_nxt  = (wp == LAST_PTR) ? '0 : wp + PW'(1);
  assign rp_nxt  = (rp == LAST_PTR) ? '0 : rp + PW'(1);
  assign bad_id  = ({1'b0, qid_q} >= QID_LIM);
  assign full    = (wp_nxt == rp);
  assign empty   = (wp == rp);
  assign send_ok = ~bad_id & (cmd_q == CMD_SEND) & ~full;
  assign recv_ok = ~bad_id & (cmd_q == CMD_RECV) & ~empty;
  assign slot_base = SAW'(qid_q[QW-1:0]) * SAW'(QUEUE_SLOTS);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LAST_SLOT) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_free_i) state_d = recv_ok ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    ptr_we      = 1'b0;
    ptr_waddr   = qid_q[QW-1:0];
    ptr_wdata   = '0;
    slot_op_o   = '0;
    slot_addr_o = slot_base + SAW'(wp);
    rsp_ctl_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ptr_we        = 1'b1;
        ptr_waddr     = clr_cnt_q[QW-1:0];
        slot_op_o.clr = 1'b1;
        slot_addr_o   = clr_cnt_q;
      end
      ST_IDLE: begin
      end
      ST_LOOK: begin
        if (out_free_i) begin
          if (send_ok) begin
            ptr_we         = 1'b1;
            ptr_wdata      = {rp, wp_nxt};
            slot_op_o.wr   = 1'b1;
            rsp_ctl_o.load = 1'b1;
            rsp_ctl_o.ok   = 1'b1;
          end else if (recv_ok) begin
            ptr_we       = 1'b1;
            ptr_wdata    = {rp_nxt, wp};
            slot_op_o.rd = 1'b1;
            slot_addr_o  = slot_base + SAW'(rp);
          end else begin
            rsp_ctl_o.load = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        rsp_ctl_o.load     = 1'b1;
        rsp_ctl_o.ok       = 1'b1;
        rsp_ctl_o.from_mem = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cmd_q     <= CMD_SEND;
      qid_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + SAW'(1);
      end
      if (accept) begin
        cmd_q <= command_i;
        qid_q <= queue_id_i;
      end
    end
  end

endmodule

@@ rtl/core/per_process_mailbox_rings_unit.sv @@
// Top level of the per-process mailbox rings: command capture, result
// register and the sequencer and slot store. Depends on ppmr_pkg, the two
// channel interfaces, ppmr_ctrl and ppmr_slots.
//
//   channel  dir  handshake      word
//   cmd_i    in   valid/ready    command, queue_id, sender_id, msg_type,
//                                payload, length
//   rsp_o    out  valid/ready    ok, out_sender_id, out_type, out_payload
//
// A send, a failed receive or a bad id loads its result after the pointer
// memory read; a good receive loads it after the pointer memory read and
// then the slot memory read. The next word is taken in the cycle after the
// result loads. After reset a clearing pass over all NUM_QUEUES*QUEUE_SLOTS
// slots zeroes the payload lanes and pointer memory; cmd_i.ready stays low.
// A stalled result holds the sequencer before it commits the next word.
module per_process_mailbox_rings_unit #(
  parameter int unsigned NUM_QUEUES    = 256,
  parameter int unsigned QUEUE_SLOTS   = 16,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppmr_cmd_if.sink    cmd_i,
  ppmr_rsp_if.source  rsp_o
);
  import ppmr_pkg::*;

  localparam int unsigned SLOTS = NUM_QUEUES * QUEUE_SLOTS;
  localparam int unsigned SAW   = $clog2(SLOTS);

  logic              in_ready;
  logic              accept;
  logic              out_free;
  slot_op_t          slot_op;
  logic [SAW-1:0]    slot_addr;
  rsp_ctl_t          rsp_ctl;

  logic [ID_W-1:0]   snd_q;
  logic [TYPE_W-1:0] typ_q;
  logic [PAY_W-1:0]  pay_q;
  logic [LEN_W-1:0]  len_q;

  logic [ID_W-1:0]   slot_snd;
  logic [TYPE_W-1:0] slot_typ;
  logic [PAY_W-1:0]  slot_pay;

  logic              out_valid_q;
  logic              ok_q;
  logic [ID_W-1:0]   out_snd_q;
  logic [TYPE_W-1:0] out_typ_q;
  logic [PAY_W-1:0]  out_pay_q;

  assign cmd_i.ready = in_ready;
  assign accept      = cmd_i.valid & in_ready;
  assign out_free    = ~out_valid_q | rsp_o.ready;

  ppmr_ctrl #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (in_ready),
    .command_i   (cmd_i.command),
    .queue_id_i  (cmd_i.queue_id),
    .out_free_i  (out_free),
    .slot_op_o   (slot_op),
    .slot_addr_o (slot_addr),
    .rsp_ctl_o   (rsp_ctl)
  );

  ppmr_slots #(
    .DEPTH         (SLOTS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_slots (
    .clk_i     (clk_i),
    .op_i      (slot_op),
    .addr_i    (slot_addr),
    .sender_i  (snd_q),
    .type_i    (typ_q),
    .payload_i (pay_q),
    .length_i  (len_q),
    .sender_o  (slot_snd),
    .type_o    (slot_typ),
    .payload_o (slot_pay)
  );

  // Hold the send fields until the sequencer commits the word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      snd_q <= cmd_i.sender_id;
      typ_q <= cmd_i.msg_type;
      pay_q <= cmd_i.payload;
      len_q <= cmd_i.length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ctl.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ctl.load) begin
      ok_q      <= rsp_ctl.ok;
      out_snd_q <= rsp_ctl.from_mem ? slot_snd : '0;
      out_typ_q <= rsp_ctl.from_mem ? slot_typ : '0;
      out_pay_q <= rsp_ctl.from_mem ? slot_pay : '0;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.ok            = ok_q;
  assign rsp_o.out_sender_id = out_snd_q;
  assign rsp_o.out_type      = out_typ_q;
  assign rsp_o.out_payload   = out_pay_q;

endmodule
